/* hw/rtl/mse_pkg.sv */
`default_nettype none
package mse_pkg;

	localparam int XLEN      = 64;
	localparam int ADDR_W    = 32;
	localparam int INSTR_W   = 32;
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = 5;
	localparam int OUT_W     = 112;

	localparam logic [ADDR_W-1:0] START_RESET    = 32'hBFC0_0000;
	localparam logic [ADDR_W-1:0] SYSCALL_VECTOR = 32'h8000_0180;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_SQ      = 6'h1F;

	// SPECIAL function codes
	localparam logic [5:0] FN_NOP     = 6'h00;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_SLTU    = 6'h2B;
	localparam logic [5:0] FN_DADDU   = 6'h2D;

	typedef struct packed {
		logic [ADDR_W-1:0]    next_address;
		logic                 reg_written;
		logic [REG_IDX_W-1:0] dest_index;
		logic [XLEN-1:0]      written_value;
		logic                 branch_taken;
		logic                 syscall_raised;
		logic                 unknown_opcode;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/mse_ram.sv */
`default_nettype none
module mse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/mse_exec.sv */
`default_nettype none
module mse_exec (
	input  wire logic [31:0]  instr,
	input  wire logic [63:0]  rs_val,
	input  wire logic [63:0]  rt_val,
	input  wire logic [31:0]  pc,
	output      mse_pkg::res_t res
);
	import mse_pkg::*;

	logic [5:0]           op;
	logic [5:0]           funct;
	logic [REG_IDX_W-1:0] rt;
	logic [REG_IDX_W-1:0] rd;
	logic [15:0]          imm;
	logic [31:0]          imm_sx;
	logic [31:0]          sum32;
	logic [31:0]          pc_inc;
	logic                 wr;
	logic [REG_IDX_W-1:0] dst;
	logic [XLEN-1:0]      val;

	assign op     = instr[31:26];
	assign rt     = instr[20:16];
	assign rd     = instr[15:11];
	assign imm    = instr[15:0];
	assign funct  = instr[5:0];
	assign imm_sx = {{16{imm[15]}}, imm};
	assign sum32  = rs_val[31:0] + imm_sx;
	assign pc_inc = pc + 32'd4;

	always_comb begin
		res = '0;
		res.next_address = pc_inc;
		wr  = 1'b0;
		dst = '0;
		val = '0;
		case (op)
			OP_SPECIAL: begin
				case (funct)
					FN_NOP: begin
					end
					FN_SYSCALL: begin
						res.next_address   = SYSCALL_VECTOR;
						res.syscall_raised = 1'b1;
					end
					FN_SLTU: begin
						wr  = 1'b1;
						dst = rd;
						val = {63'd0, (rs_val < rt_val)};
					end
					FN_DADDU: begin
						wr  = 1'b1;
						dst = rd;
						val = rs_val + rt_val;
					end
					default: begin
						res.unknown_opcode = 1'b1;
					end
				endcase
			end
			OP_ADDIU: begin
				wr  = 1'b1;
				dst = rt;
				val = {{32{sum32[31]}}, sum32};
			end
			OP_LUI: begin
				wr  = 1'b1;
				dst = rt;
				val = {{32{imm[15]}}, imm, 16'd0};
			end
			OP_SQ: begin
			end
			OP_BNE: begin
				if (rs_val != rt_val) begin
					res.next_address = pc_inc + {imm_sx[29:0], 2'b00};
					res.branch_taken = 1'b1;
				end
			end
			default: begin
				res.unknown_opcode = 1'b1;
			end
		endcase
		// drop writes to r0
		if (wr && dst != '0) begin
			res.reg_written   = 1'b1;
			res.dest_index    = dst;
			res.written_value = val;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/mips64_subset_executor_top.sv */
`default_nettype none
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------
// s_*       | in        | instruction request, tdata[31:0] instruction_word
// m_*       | out       | retire result, fields listed at m_tdata
// cfg_*     | in        | start_address write, reloads the program counter
//
// One instruction per cycle unless m_tready stalls it; execute, then output register.
// Register operands are read from two mirrored register-file RAMs at accept; the
// result is written back as the instruction leaves the execute stage, with a
// bypass for a write landing in the same cycle as the read.
// Reset clears the per-register valid bits (an unwritten register reads zero) and
// loads the program counter with 0xBFC00000. A stalled m_tready holds the execute
// stage and the input while the output register is full.
module mips64_subset_executor_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [31:0]                 s_tdata,   // [31:0] instruction_word
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	// [31:0] next_address, [32] reg_written, [37:33] dest_index,
	// [101:38] written_value, [102] branch_taken, [103] syscall_raised,
	// [104] unknown_opcode, [111:105] zero
	output      logic [mse_pkg::OUT_W-1:0]   m_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [31:0]                 cfg_wdata
);
	import mse_pkg::*;

	logic                 s_accept;
	logic [REG_IDX_W-1:0] rs_idx;
	logic [REG_IDX_W-1:0] rt_idx;
	logic [XLEN-1:0]      ram_a;
	logic [XLEN-1:0]      ram_b;

	logic                 valid_s1;
	logic [INSTR_W-1:0]   instr_s1;
	logic                 a_vld_s1;
	logic                 b_vld_s1;
	logic                 fwd_a_s1;
	logic                 fwd_b_s1;
	logic [XLEN-1:0]      fwd_val_s1;
	logic                 s1_adv;

	logic [REG_COUNT-1:0] valid_q;
	logic [ADDR_W-1:0]    pc_q;
	logic [XLEN-1:0]      op_a;
	logic [XLEN-1:0]      op_b;
	res_t                 res;
	res_t                 out_q;
	logic                 out_valid_q;
	logic                 wb_en;

	assign rs_idx   = s_tdata[25:21];
	assign rt_idx   = s_tdata[20:16];
	assign s1_adv   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | s1_adv;
	assign s_accept = s_tvalid & s_tready;
	assign wb_en    = s1_adv & res.reg_written;

	mse_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (wb_en),
		.waddr (res.dest_index),
		.wdata (res.written_value),
		.re    (s_accept),
		.raddr (rs_idx),
		.rdata (ram_a)
	);

	mse_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (wb_en),
		.waddr (res.dest_index),
		.wdata (res.written_value),
		.re    (s_accept),
		.raddr (rt_idx),
		.rdata (ram_b)
	);

	// bypass wins over the RAM, an unwritten register reads zero
	always_comb begin
		op_a = fwd_a_s1 ? fwd_val_s1 : (a_vld_s1 ? ram_a : '0);
		op_b = fwd_b_s1 ? fwd_val_s1 : (b_vld_s1 ? ram_b : '0);
	end

	mse_exec u_exec (
		.instr  (instr_s1),
		.rs_val (op_a),
		.rt_val (op_b),
		.pc     (pc_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_q     <= '0;
			pc_q        <= START_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (wb_en) begin
				valid_q[res.dest_index] <= 1'b1;
			end
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (s1_adv) begin
				pc_q <= res.next_address;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			instr_s1   <= s_tdata;
			a_vld_s1   <= valid_q[rs_idx];
			b_vld_s1   <= valid_q[rt_idx];
			fwd_a_s1   <= wb_en && (res.dest_index == rs_idx);
			fwd_b_s1   <= wb_en && (res.dest_index == rt_idx);
			fwd_val_s1 <= res.written_value;
		end
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.unknown_opcode, out_q.syscall_raised,
		out_q.branch_taken, out_q.written_value, out_q.dest_index,
		out_q.reg_written, out_q.next_address};

	a_r0_never_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0])
		else $error("register zero marked as written");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |-> res.dest_index != '0)
		else $error("write-back targets register zero");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(instr_s1)))
		else $error("execute stage changed while stalled");

	a_no_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.reg_written) |->
		(out_q.dest_index == '0 && out_q.written_value == '0))
		else $error("result without write carries a destination");

	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !cfg_we) |=> pc_q == $past(res.next_address))
		else $error("program counter did not follow retired instruction");

endmodule
`default_nettype wire

/* sim/mips64_subset_executor_top_test.sv */
module mips64_subset_executor_top_test;
	import mse_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int N_DIR        = 23;
	localparam int PHASE_ITEMS  = 550;
	localparam int PRESSURE_AT  = 1200;
	localparam int PRESSURE_LEN = 300;
	localparam int TAIL_CYCLES  = 6;

	localparam logic [5:0] FN_BAD = 6'h3F;

	typedef struct packed {
		logic [31:0] word;
		logic        typed;
		res_t        want;
	} dir_row_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [111:0] m_tdata;
	logic         cfg_we    = 1'b0;
	logic [31:0]  cfg_wdata = '0;

	logic [63:0] gpr_model [REG_COUNT];
	logic [31:0] pc_model;
	res_t        retire_q [$];
	dir_row_t    dir_rows [N_DIR];

	int fails         = 0;
	int results_seen  = 0;
	int stall_left    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	mips64_subset_executor_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	initial begin
		#(CLK_PERIOD * 200000);
		$display("mips64_subset_executor_top_test NOT OK");
		$finish;
	end

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sh, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic res_t outcome(logic [31:0] nxt, logic wr, logic [4:0] dst,
			logic [63:0] val, logic br, logic sys, logic unk);
		res_t r;
		r.next_address   = nxt;
		r.reg_written    = wr;
		r.dest_index     = dst;
		r.written_value  = val;
		r.branch_taken   = br;
		r.syscall_raised = sys;
		r.unknown_opcode = unk;
		return r;
	endfunction

	function automatic dir_row_t chk(logic [31:0] w);
		return '{w, 1'b0, '0};
	endfunction

	function automatic dir_row_t fixed(logic [31:0] w, res_t r);
		return '{w, 1'b1, r};
	endfunction

	// Execute one instruction on the shadow register file and program counter.
	function automatic res_t retire(logic [31:0] w);
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [63:0] a;
		logic [63:0] b;
		logic [31:0] sum;
		res_t        r;
		op  = w[31:26];
		rs  = w[25:21];
		rt  = w[20:16];
		rd  = w[15:11];
		imm = w[15:0];
		fn  = w[5:0];
		a   = gpr_model[rs];
		b   = gpr_model[rt];
		r   = '0;
		r.next_address = pc_model + 32'd4;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_NOP: ;
					FN_SYSCALL: begin
						r.next_address   = SYSCALL_VECTOR;
						r.syscall_raised = 1'b1;
					end
					FN_SLTU: begin
						r.reg_written   = 1'b1;
						r.dest_index    = rd;
						r.written_value = {63'd0, a < b};
					end
					FN_DADDU: begin
						r.reg_written   = 1'b1;
						r.dest_index    = rd;
						r.written_value = a + b;
					end
					default: r.unknown_opcode = 1'b1;
				endcase
			end
			OP_ADDIU: begin
				sum             = a[31:0] + {{16{imm[15]}}, imm};
				r.reg_written   = 1'b1;
				r.dest_index    = rt;
				r.written_value = {{32{sum[31]}}, sum};
			end
			OP_LUI: begin
				r.reg_written   = 1'b1;
				r.dest_index    = rt;
				r.written_value = {{32{imm[15]}}, imm, 16'h0000};
			end
			OP_SQ: ;
			OP_BNE: begin
				if (a != b) begin
					r.next_address = pc_model + 32'd4 + {{14{imm[15]}}, imm, 2'b00};
					r.branch_taken = 1'b1;
				end
			end
			default: r.unknown_opcode = 1'b1;
		endcase
		// r0 stays zero: drop the write and report nothing
		if (r.reg_written && r.dest_index == 5'd0) begin
			r.reg_written   = 1'b0;
			r.written_value = '0;
		end
		if (r.reg_written)
			gpr_model[r.dest_index] = r.written_value;
		pc_model = r.next_address;
		return r;
	endfunction

	// Favor r0..r3 half the time so that results feed the next instructions.
	function automatic logic [4:0] pick_reg();
		logic [31:0] r;
		r = $urandom;
		return r[31] ? {3'b000, r[1:0]} : r[4:0];
	endfunction

	function automatic logic [31:0] rand_instr();
		logic [31:0] raw;
		int unsigned pick;
		raw  = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return itype(OP_ADDIU, pick_reg(), pick_reg(), raw[15:0]);
		if (pick < 32)
			return itype(OP_LUI, raw[25:21], pick_reg(), raw[15:0]);
		if (pick < 47)
			return itype(OP_BNE, pick_reg(), pick_reg(), raw[15:0]);
		if (pick < 57)
			return rtype(pick_reg(), pick_reg(), pick_reg(), raw[10:6], FN_SLTU);
		if (pick < 70)
			return rtype(pick_reg(), pick_reg(), pick_reg(), raw[10:6], FN_DADDU);
		if (pick < 75)
			return {OP_SPECIAL, raw[25:6], FN_NOP};
		if (pick < 78)
			return {OP_SPECIAL, raw[25:6], FN_SYSCALL};
		if (pick < 82)
			return {OP_SQ, raw[25:0]};
		if (pick < 89) begin
			while (raw[31:26] inside {OP_SPECIAL, OP_BNE, OP_ADDIU, OP_LUI, OP_SQ})
				raw = $urandom;
			return raw;
		end
		if (pick < 94) begin
			while (raw[5:0] inside {FN_NOP, FN_SYSCALL, FN_SLTU, FN_DADDU})
				raw = $urandom;
			return {OP_SPECIAL, raw[25:0]};
		end
		return raw;
	endfunction

	task automatic send_instr(input dir_row_t row);
		res_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row.word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = retire(row.word);
		retire_q.push_back(row.typed ? row.want : predicted);
	endtask

	task automatic run_random(input int n);
		repeat (n) send_instr(chk(rand_instr()));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (retire_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic load_start(input logic [31:0] addr);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we   <= 1'b0;
		pc_model = addr;
	endtask

	task automatic cmp_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$display("%0t: %s expected %h got %h", $time, name, exp, act);
			fails++;
		end
	endtask

	task automatic check_retire(input logic [111:0] bus);
		res_t want;
		if (retire_q.size() == 0) begin
			$display("%0t: result with none expected, expected nothing got %h", $time, bus);
			fails++;
		end else begin
			want = retire_q.pop_front();
			cmp_field("next_address", 64'(want.next_address), 64'(bus[31:0]));
			cmp_field("reg_written", 64'(want.reg_written), 64'(bus[32]));
			cmp_field("dest_index", 64'(want.dest_index), 64'(bus[37:33]));
			cmp_field("written_value", want.written_value, bus[101:38]);
			cmp_field("branch_taken", 64'(want.branch_taken), 64'(bus[102]));
			cmp_field("syscall_raised", 64'(want.syscall_raised), 64'(bus[103]));
			cmp_field("unknown_opcode", 64'(want.unknown_opcode), 64'(bus[104]));
		end
	endtask

	initial begin : retire_sink
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				check_retire(m_tdata);
				results_seen++;
				if (results_seen == PRESSURE_AT)
					stall_left = PRESSURE_LEN;
			end
			// hold off long enough to back the pipeline up into the input
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		for (int i = 0; i < REG_COUNT; i++)
			gpr_model[i] = '0;
		pc_model = START_RESET;

		dir_rows = '{
			fixed(32'h0000_0000, outcome(32'hBFC0_0004, 1'b0, 5'd0, 64'd0, 1'b0, 1'b0, 1'b0)),
			fixed(itype(OP_LUI, 5'd0, 5'd1, 16'hFFFF),
				outcome(32'hBFC0_0008, 1'b1, 5'd1, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 1'b0, 1'b0)),
			fixed(itype(OP_ADDIU, 5'd0, 5'd2, 16'h7FFF),
				outcome(32'hBFC0_000C, 1'b1, 5'd2, 64'h7FFF, 1'b0, 1'b0, 1'b0)),
			fixed(itype(OP_LUI, 5'd0, 5'd0, 16'h1234),
				outcome(32'hBFC0_0010, 1'b0, 5'd0, 64'd0, 1'b0, 1'b0, 1'b0)),
			chk(itype(OP_ADDIU, 5'd1, 5'd3, 16'hFFFF)),
			chk(itype(OP_LUI, 5'd0, 5'd5, 16'h7FFF)),
			chk(itype(OP_ADDIU, 5'd5, 5'd5, 16'h7FFF)),
			chk(itype(OP_ADDIU, 5'd5, 5'd5, 16'h7FFF)),
			chk(itype(OP_ADDIU, 5'd5, 5'd5, 16'h7FFF)),
			chk(rtype(5'd2, 5'd1, 5'd7, 5'd0, FN_SLTU)),
			chk(rtype(5'd1, 5'd2, 5'd8, 5'd0, FN_SLTU)),
			chk(rtype(5'd1, 5'd1, 5'd9, 5'd0, FN_DADDU)),
			chk(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_DADDU)),
			chk({OP_SPECIAL, 20'hFFFFF, FN_NOP}),
			chk(itype(OP_SQ, 5'd31, 5'd31, 16'hFFFF)),
			chk(itype(OP_BNE, 5'd1, 5'd2, 16'h7FFF)),
			chk(itype(OP_BNE, 5'd1, 5'd2, 16'h8000)),
			chk(itype(OP_BNE, 5'd1, 5'd1, 16'h1234)),
			chk(itype(OP_BNE, 5'd0, 5'd0, 16'hFFFF)),
			fixed(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL),
				outcome(SYSCALL_VECTOR, 1'b0, 5'd0, 64'd0, 1'b0, 1'b1, 1'b0)),
			fixed(32'hFFFF_FFFF, outcome(32'h8000_0184, 1'b0, 5'd0, 64'd0, 1'b0, 1'b0, 1'b1)),
			fixed(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_BAD),
				outcome(32'h8000_0188, 1'b0, 5'd0, 64'd0, 1'b0, 1'b0, 1'b1)),
			chk(itype(OP_BNE, 5'd1, 5'd0, 16'h8000))
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 81;
		for (int i = 0; i < N_DIR; i++)
			send_instr(dir_rows[i]);

		// near the top of the address space so that the program counter wraps
		load_start(32'hFFFF_FFF0);
		run_random(PHASE_ITEMS);

		send_idle_pct = 81;
		recv_idle_pct = 7;
		load_start(32'h0000_0000);
		run_random(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_start($urandom);
		run_random(PHASE_ITEMS / 2);
		load_start(32'hFFFF_FFFF);
		run_random(PHASE_ITEMS - PHASE_ITEMS / 2);

		drain();
		if (fails == 0)
			$display("mips64_subset_executor_top_test OK");
		else
			$display("mips64_subset_executor_top_test NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_exec.sv
hw/rtl/mips64_subset_executor_top.sv
sim/mips64_subset_executor_top_test.sv
